>>> hw/rtl/positional_list_engine_assert.svh
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PLE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ple assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ple assertion failed");

`endif

>>> hw/rtl/ple_pkg.sv
package ple_pkg;

	localparam int DEPTH_DEF = 32;

	localparam int OP_W   = 4;
	localparam int POS_W  = 6;
	localparam int DATA_W = 32;
	localparam int ST_W   = 3;
	localparam int CNT_W  = 6;

	localparam logic [OP_W-1:0] OP_INS_HEAD = 4'd0;
	localparam logic [OP_W-1:0] OP_INS_TAIL = 4'd1;
	localparam logic [OP_W-1:0] OP_INS_AT   = 4'd2;
	localparam logic [OP_W-1:0] OP_RM_HEAD  = 4'd3;
	localparam logic [OP_W-1:0] OP_RM_TAIL  = 4'd4;
	localparam logic [OP_W-1:0] OP_RM_AT    = 4'd5;
	localparam logic [OP_W-1:0] OP_SEARCH   = 4'd6;
	localparam logic [OP_W-1:0] OP_SHOW_FWD = 4'd7;
	localparam logic [OP_W-1:0] OP_SHOW_REV = 4'd8;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
	localparam logic [ST_W-1:0] ST_FOUND    = 3'd4;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic signed [DATA_W-1:0] item;
		logic [CNT_W-1:0]         entry_count;
		logic                     last;
	} result_t;

endpackage

>>> hw/rtl/positional_list_engine.sv
// Bounded ordered list of signed 32-bit values held in one DEPTH-entry memory
// with a registered read port. A command is taken when start is high and busy
// is low; each result shows on result for one cycle with done high and cannot
// be held off, so the receiver must take every transfer as it comes. Errors
// (full, empty, bad position) and inserts at the tail answer without a walk.
// Work that walks entries (shifting on a positional insert or remove, search,
// listing) reads one entry per cycle through the single read port. Listing
// streams one result per cycle, the final one marked by last.
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
	parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ple_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              done,
	output ple_pkg::result_t  result
);
	import ple_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_WALK  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]              state_q;
	logic [CW-1:0]           count_q;
	logic                    done_q;
	logic                    found_q;
	logic                    valid_s1;
	result_t                 result_q;

	logic [OP_W-1:0]         op_q;
	logic [AW-1:0]           pos_q;
	logic signed [DATA_W-1:0] value_q;
	logic [AW-1:0]           ptr_q;
	logic [AW-1:0]           end_q;
	logic                    up_q;
	logic signed [DATA_W-1:0] removed_q;
	logic [AW-1:0]           addr_s1;
	logic                    last_s1;
	logic signed [DATA_W-1:0] rdata_s1;

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	logic                    accept;
	logic                    full;
	logic                    empty;
	logic [XW-1:0]           cnt_x;
	logic [XW-1:0]           tgt_x;
	logic [AW-1:0]           cnt_m1;
	logic                    d_emit;
	logic [ST_W-1:0]         d_status;
	logic                    d_walk;
	logic                    d_fin;
	logic [AW-1:0]           d_ptr;
	logic [AW-1:0]           d_end;
	logic                    d_up;
	logic [AW-1:0]           d_pos;

	logic                    ins_op;
	logic                    rm_op;
	logic                    list_op;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic signed [DATA_W-1:0] wdata;

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;
	assign accept = start && !busy;

	assign full   = count_q == CW'(DEPTH);
	assign empty  = count_q == '0;
	assign cnt_x  = XW'(count_q);
	assign cnt_m1 = AW'(count_q - CW'(1));

	assign ins_op  = op_q == OP_INS_HEAD || op_q == OP_INS_TAIL || op_q == OP_INS_AT;
	assign rm_op   = op_q == OP_RM_HEAD || op_q == OP_RM_TAIL || op_q == OP_RM_AT;
	assign list_op = op_q == OP_SHOW_FWD || op_q == OP_SHOW_REV;

	// command decode against the current count
	always_comb begin
		d_emit   = 1'b0;
		d_status = ST_OK;
		d_walk   = 1'b0;
		d_fin    = 1'b0;
		d_ptr    = '0;
		d_end    = '0;
		d_up     = 1'b0;
		d_pos    = '0;
		tgt_x    = '0;
		case (cmd.op)
			OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
				if (cmd.op == OP_INS_TAIL) begin
					tgt_x = cnt_x;
				end else if (cmd.op == OP_INS_AT) begin
					tgt_x = XW'(cmd.position);
				end
				if (full) begin
					d_emit   = 1'b1;
					d_status = ST_FULL;
				end else if (tgt_x > cnt_x) begin
					d_emit   = 1'b1;
					d_status = ST_BADPOS;
				end else begin
					d_pos = AW'(tgt_x);
					if (tgt_x == cnt_x) begin
						d_fin = 1'b1;
					end else begin
						d_walk = 1'b1;
						d_ptr  = cnt_m1;
						d_end  = AW'(tgt_x);
					end
				end
			end
			OP_RM_HEAD, OP_RM_TAIL, OP_RM_AT: begin
				if (cmd.op == OP_RM_TAIL) begin
					tgt_x = XW'(cnt_x - XW'(1));
				end else if (cmd.op == OP_RM_AT) begin
					tgt_x = XW'(cmd.position);
				end
				if (empty) begin
					d_emit   = 1'b1;
					d_status = ST_EMPTY;
				end else if (tgt_x >= cnt_x) begin
					d_emit   = 1'b1;
					d_status = ST_BADPOS;
				end else begin
					d_walk = 1'b1;
					d_pos  = AW'(tgt_x);
					d_ptr  = AW'(tgt_x);
					d_end  = cnt_m1;
					d_up   = 1'b1;
				end
			end
			OP_SEARCH, OP_SHOW_FWD: begin
				if (empty) begin
					d_emit   = 1'b1;
					d_status = ST_EMPTY;
				end else begin
					d_walk = 1'b1;
					d_end  = cnt_m1;
					d_up   = 1'b1;
				end
			end
			OP_SHOW_REV: begin
				if (empty) begin
					d_emit   = 1'b1;
					d_status = ST_EMPTY;
				end else begin
					d_walk = 1'b1;
					d_ptr  = cnt_m1;
				end
			end
			default: begin
				d_emit = 1'b0;
			end
		endcase
	end

	// entry write: shift during the walk, new value at the end of an insert
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rdata_s1;
		if (valid_s1 && ins_op) begin
			we    = 1'b1;
			waddr = AW'(addr_s1 + AW'(1));
		end else if (valid_s1 && rm_op && addr_s1 != pos_q) begin
			we    = 1'b1;
			waddr = AW'(addr_s1 - AW'(1));
		end else if (state_q == S_FIN && ins_op) begin
			we    = 1'b1;
			waddr = pos_q;
			wdata = value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_s1 <= mem_q[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			done_q   <= (valid_s1 && list_op) || (accept && d_emit) || state_q == S_FIN;
			valid_s1 <= state_q == S_WALK;
			if (valid_s1 && op_q == OP_SEARCH && rdata_s1 == value_q) begin
				found_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						if (d_walk) begin
							state_q <= S_WALK;
						end else if (d_fin) begin
							state_q <= S_FIN;
						end
					end
				end
				S_WALK: begin
					if (ptr_q == end_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= list_op ? S_IDLE : S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
					if (ins_op) begin
						count_q <= count_q + CW'(1);
					end else if (rm_op) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			op_q    <= cmd.op;
			value_q <= cmd.value;
			pos_q   <= d_pos;
			ptr_q   <= d_ptr;
			end_q   <= d_end;
			up_q    <= d_up;
			result_q <= '{status: d_status, item: '0, entry_count: CNT_W'(count_q), last: 1'b1};
		end
		if (state_q == S_WALK) begin
			ptr_q   <= up_q ? AW'(ptr_q + AW'(1)) : AW'(ptr_q - AW'(1));
			addr_s1 <= ptr_q;
			last_s1 <= ptr_q == end_q;
		end
		if (valid_s1 && rm_op && addr_s1 == pos_q) begin
			removed_q <= rdata_s1;
		end
		if (valid_s1 && list_op) begin
			result_q <= '{status: ST_OK, item: rdata_s1, entry_count: CNT_W'(count_q),
				last: last_s1};
		end
		if (state_q == S_FIN) begin
			if (ins_op) begin
				result_q <= '{status: ST_OK, item: '0,
					entry_count: CNT_W'(count_q + CW'(1)), last: 1'b1};
			end else if (rm_op) begin
				result_q <= '{status: ST_OK, item: removed_q,
					entry_count: CNT_W'(count_q - CW'(1)), last: 1'b1};
			end else begin
				result_q <= '{status: found_q ? ST_FOUND : ST_NOTFOUND, item: '0,
					entry_count: CNT_W'(count_q), last: 1'b1};
			end
		end
	end

	`PLE_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
	`PLE_ASSERT_NEXT(a_list_stream, done_q && !result_q.last, done_q)
	`PLE_ASSERT_IMPL(a_write_busy, we, state_q != S_IDLE)
	`PLE_ASSERT_NEXT(a_fin_done, state_q == S_FIN, done_q && state_q == S_IDLE)

endmodule
